@@ sv/stx_etx_response_deframer_assert.svh @@
// Assertion macros for the STX/ETX response deframer.
// Used by the controller and datapath modules; no other dependencies.
`ifndef STX_ETX_RESPONSE_DEFRAMER_ASSERT_SVH
`define STX_ETX_RESPONSE_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
`define STX_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define STX_ASSERT_IMPL(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`else
`define STX_ASSERT(lbl, clk, rst, prop)
`define STX_ASSERT_IMPL(lbl, clk, rst, pre, post)
`endif
`endif

@@ sv/stxdf_pkg.sv @@
// Shared types and constants of the STX/ETX response deframer.
// No dependencies.
package stxdf_pkg;
   localparam int RespDepth = 256;
   localparam logic [7:0] MIN_FRAME = 8'd8;
   localparam logic [7:0] REPLY_BIT = 8'h80;

   localparam logic [1:0] CMD_RX    = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] EV_NONE     = 2'd0;
   localparam logic [1:0] EV_RESPONSE = 2'd1;
   localparam logic [1:0] EV_OTHER    = 2'd2;
   localparam logic [1:0] EV_REJECT   = 2'd3;

   localparam logic [7:0] REG_START  = 8'd0;
   localparam logic [7:0] REG_END    = 8'd1;
   localparam logic [7:0] REG_OPCODE = 8'd2;
   localparam logic [7:0] REG_MATCH  = 8'd3;

   typedef enum logic [2:0] {
      OFF_HEAD, OFF_LEN, OFF_END, OFF_OPC, OFF_COPY
   } off_sel_type;

   typedef struct packed {
      logic        item_start;
      logic        push;
      logic        rd_en;
      off_sel_type rd_sel;
      logic        drop_one;
      logic        drop_len;
      logic        len_load;
      logic        copy_start;
      logic        copy_step;
      logic        capture;
      logic        flag_clr;
      logic        resp_rd;
      logic        data_take;
      logic        ev_wr;
      logic [1:0]  ev;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_lt2;
      logic count_lt_len;
      logic push_lt_len;
      logic win_is_start;
      logic win_is_end;
      logic win_is_opc;
      logic len_short;
      logic idx_ok;
      logic copy_last;
      logic out_free;
      logic cfg_wr;
      logic match_en;
   } dp_status_type;
endpackage

@@ sv/stxdf_if.sv @@
// Handshake channel interfaces of the STX/ETX response deframer.
// No dependencies.
interface stxdf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] rx_byte;
   logic [7:0] read_index;
   modport source (output valid, cmd, rx_byte, read_index, input ready);
   modport sink (input valid, cmd, rx_byte, read_index, output ready);
endinterface

interface stxdf_rsp_if;
   logic       valid;
   logic       ready;
   logic       response_ready;
   logic [7:0] response_length;
   logic [7:0] read_data;
   logic [1:0] frame_event;
   modport source (output valid, response_ready, response_length, read_data, frame_event,
                   input ready);
   modport sink (input valid, response_ready, response_length, read_data, frame_event,
                 output ready);
endinterface

interface stxdf_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ sv/stxdf_dpath.sv @@
// Datapath: byte window memory, response memory, config registers, result register.
// Depends on stxdf_pkg and the assertion macro header.
`include "stx_etx_response_deframer_assert.svh"
module stxdf_dpath #(
   parameter int WINDOW_DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  stxdf_pkg::dp_cmd_type    ctl,
   output stxdf_pkg::dp_status_type st,
   input  logic [7:0]               req_rx_byte,
   input  logic [7:0]               req_read_index,
   input  logic                     csr_valid,
   input  logic [7:0]               csr_index,
   input  logic [7:0]               csr_data,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic                     rsp_response_ready,
   output logic [7:0]               rsp_response_length,
   output logic [7:0]               rsp_read_data,
   output logic [1:0]               rsp_frame_event
);
   import stxdf_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int CW = $clog2(WINDOW_DEPTH + 1);
   localparam logic [AW:0] DEPTH_W = (AW + 1)'(WINDOW_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

   logic [7:0] win_mem [WINDOW_DEPTH];
   logic [7:0] resp_mem [RespDepth];

   logic [7:0]    start_ff, end_ff, opc_ff;
   logic          match_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    len_ff;
   logic [7:0]    k_ff;
   logic          wr_v_ff;
   logic [7:0]    wk_ff;
   logic [7:0]    win_rdata_ff;
   logic [7:0]    resp_rdata_ff;
   logic [7:0]    cap_ff;
   logic          flag_ff;
   logic [7:0]    data_ff;
   logic [1:0]    ev_ff;
   logic          rv_ff;
   logic          o_flag_ff;
   logic [7:0]    o_len_ff, o_data_ff;
   logic [1:0]    o_ev_ff;

   logic [7:0]    rd_off;
   logic [AW:0]   rd_sum, wr_sum, drop_sum;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [7:0]    drop_n;
   logic [CW-1:0] count_push;

   // Select read offset from the head
   always_comb begin
      case (ctl.rd_sel)
         OFF_HEAD: rd_off = 8'd0;
         OFF_LEN:  rd_off = 8'd1;
         OFF_END:  rd_off = len_ff - 8'd1;
         OFF_OPC:  rd_off = 8'd6;
         OFF_COPY: rd_off = k_ff;
         default:  rd_off = 8'd0;
      endcase
   end

   // Circular addressing: one compare and subtract wraps the sum
   assign rd_sum  = {1'b0, head_ff} + (AW + 1)'(rd_off);
   assign rd_addr = (rd_sum >= DEPTH_W) ? AW'(rd_sum - DEPTH_W) : AW'(rd_sum);
   assign wr_sum  = {1'b0, head_ff} + (AW + 1)'(count_ff);
   assign wr_addr = (wr_sum >= DEPTH_W) ? AW'(wr_sum - DEPTH_W) : AW'(wr_sum);
   assign drop_n  = ctl.drop_len ? len_ff : 8'd1;
   assign drop_sum = {1'b0, head_ff} + (AW + 1)'(drop_n);
   assign count_push = (count_ff < DEPTH_C) ? count_ff + CW'(1) : count_ff;

   // Advance head and count on push or drop
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_push;
      end else if (ctl.drop_one || ctl.drop_len) begin
         head_in  = (drop_sum >= DEPTH_W) ? AW'(drop_sum - DEPTH_W) : AW'(drop_sum);
         count_in = count_ff - CW'(drop_n);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         start_ff <= 8'd2;
         end_ff   <= 8'd3;
         opc_ff   <= 8'd0;
         match_ff <= 1'b0;
         cap_ff   <= 8'd0;
         flag_ff  <= 1'b0;
         wr_v_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         wr_v_ff  <= ctl.copy_step;
         if (csr_valid) begin
            case (csr_index)
               REG_START:  start_ff <= csr_data;
               REG_END:    end_ff   <= csr_data;
               REG_OPCODE: opc_ff   <= csr_data;
               REG_MATCH:  match_ff <= csr_data[0];
               default:    ;
            endcase
         end
         if (ctl.capture) begin
            cap_ff  <= len_ff;
            flag_ff <= 1'b1;
         end else if (ctl.flag_clr) begin
            flag_ff <= 1'b0;
         end
         if (ctl.out_load) begin
            rv_ff <= 1'b1;
         end else if (rsp_ready) begin
            rv_ff <= 1'b0;
         end
      end
   end

   // Memories and payload registers
   always_ff @(posedge clock) begin
      if (ctl.push && (count_ff < DEPTH_C)) begin
         win_mem[wr_addr] <= req_rx_byte;
      end
      if (ctl.rd_en) begin
         win_rdata_ff <= win_mem[rd_addr];
      end
      if (wr_v_ff) begin
         resp_mem[wk_ff] <= win_rdata_ff;
      end
      if (ctl.resp_rd) begin
         resp_rdata_ff <= resp_mem[req_read_index];
      end
      if (ctl.len_load) begin
         len_ff <= win_rdata_ff;
      end
      if (ctl.copy_start) begin
         k_ff <= 8'd0;
      end else if (ctl.copy_step) begin
         k_ff <= k_ff + 8'd1;
      end
      wk_ff <= k_ff;
      if (ctl.item_start) begin
         data_ff <= 8'd0;
         ev_ff   <= EV_NONE;
      end else begin
         if (ctl.data_take) begin
            data_ff <= resp_rdata_ff;
         end
         if (ctl.ev_wr) begin
            ev_ff <= ctl.ev;
         end
      end
      if (ctl.out_load) begin
         o_flag_ff <= ctl.flag_clr ? 1'b0 : flag_ff;
         o_len_ff  <= cap_ff;
         o_data_ff <= data_ff;
         o_ev_ff   <= ev_ff;
      end
   end

   // Status towards the controller
   always_comb begin
      st.count_zero   = (count_ff == '0);
      st.count_lt2    = (count_ff < CW'(2));
      st.count_lt_len = (count_ff < CW'(len_ff));
      st.push_lt_len  = (count_push < CW'(len_ff));
      st.win_is_start = (win_rdata_ff == start_ff);
      st.win_is_end   = (win_rdata_ff == end_ff);
      st.win_is_opc   = (win_rdata_ff == (opc_ff | REPLY_BIT));
      st.len_short    = (win_rdata_ff < MIN_FRAME);
      st.idx_ok       = (req_read_index < cap_ff);
      st.copy_last    = (k_ff == len_ff - 8'd1);
      st.out_free     = !rv_ff || rsp_ready;
      st.cfg_wr       = csr_valid;
      st.match_en     = match_ff;
   end

   assign rsp_valid           = rv_ff;
   assign rsp_response_ready  = o_flag_ff;
   assign rsp_response_length = o_len_ff;
   assign rsp_read_data       = o_data_ff;
   assign rsp_frame_event     = o_ev_ff;

   `STX_ASSERT(a_count_range, clock, reset, count_ff <= DEPTH_C)
   `STX_ASSERT_IMPL(a_drop_len_ok, clock, reset, ctl.drop_len, CW'(len_ff) <= count_ff)
   `STX_ASSERT_IMPL(a_capture_len, clock, reset, ctl.capture, len_ff >= MIN_FRAME)
endmodule

@@ sv/stxdf_ctrl.sv @@
// Controller: sequences receive, frame scan, response copy and result hand-off.
// Depends on stxdf_pkg and the assertion macro header.
`include "stx_etx_response_deframer_assert.svh"
module stxdf_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_cmd,
   output logic                     req_ready,
   input  stxdf_pkg::dp_status_type st,
   output stxdf_pkg::dp_cmd_type    ctl
);
   import stxdf_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CHK, S_H0, S_H1, S_LENCHK, S_ENDB, S_OPC, S_COPY, S_COPYF, S_RDR, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      hdr_ok_ff, hdr_ok_in;

   // Next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      hdr_ok_in = hdr_ok_ff;
      ctl       = '0;
      ctl.rd_sel = OFF_HEAD;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.item_start = 1'b1;
               case (req_cmd)
                  CMD_RX: begin
                     ctl.push = 1'b1;
                     state_in = (hdr_ok_ff && st.push_lt_len) ? S_OUT : S_CHK;
                  end
                  CMD_READ: begin
                     if (st.idx_ok) begin
                        ctl.resp_rd = 1'b1;
                        state_in = S_RDR;
                     end else begin
                        state_in = S_OUT;
                     end
                  end
                  CMD_CLEAR: begin
                     ctl.flag_clr = 1'b1;
                     state_in = S_OUT;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_CHK: begin
            if (st.count_zero) begin
               state_in = S_OUT;
            end else begin
               ctl.rd_en = 1'b1;
               state_in = S_H0;
            end
         end
         S_H0: begin
            if (!st.win_is_start) begin
               ctl.drop_one = 1'b1;
               hdr_ok_in = 1'b0;
               state_in = S_CHK;
            end else if (st.count_lt2) begin
               state_in = S_OUT;
            end else begin
               ctl.rd_en = 1'b1;
               ctl.rd_sel = OFF_LEN;
               state_in = S_H1;
            end
         end
         S_H1: begin
            if (st.len_short) begin
               ctl.ev_wr = 1'b1;
               ctl.ev = EV_REJECT;
               ctl.drop_one = 1'b1;
               hdr_ok_in = 1'b0;
               state_in = S_CHK;
            end else begin
               ctl.len_load = 1'b1;
               hdr_ok_in = 1'b1;
               state_in = S_LENCHK;
            end
         end
         S_LENCHK: begin
            if (st.count_lt_len) begin
               state_in = S_OUT;
            end else begin
               ctl.rd_en = 1'b1;
               ctl.rd_sel = OFF_END;
               state_in = S_ENDB;
            end
         end
         S_ENDB: begin
            hdr_ok_in = 1'b0;
            if (!st.win_is_end) begin
               ctl.ev_wr = 1'b1;
               ctl.ev = EV_REJECT;
               ctl.drop_one = 1'b1;
               state_in = S_CHK;
            end else if (st.match_en) begin
               hdr_ok_in = 1'b1;
               ctl.rd_en = 1'b1;
               ctl.rd_sel = OFF_OPC;
               state_in = S_OPC;
            end else begin
               ctl.ev_wr = 1'b1;
               ctl.ev = EV_OTHER;
               ctl.drop_len = 1'b1;
               state_in = S_CHK;
            end
         end
         S_OPC: begin
            if (st.win_is_opc) begin
               ctl.copy_start = 1'b1;
               state_in = S_COPY;
            end else begin
               ctl.ev_wr = 1'b1;
               ctl.ev = EV_OTHER;
               ctl.drop_len = 1'b1;
               hdr_ok_in = 1'b0;
               state_in = S_CHK;
            end
         end
         S_COPY: begin
            // Stream frame bytes into the response memory, one a cycle
            ctl.rd_en = 1'b1;
            ctl.rd_sel = OFF_COPY;
            ctl.copy_step = 1'b1;
            if (st.copy_last) begin
               state_in = S_COPYF;
            end
         end
         S_COPYF: begin
            ctl.capture = 1'b1;
            ctl.ev_wr = 1'b1;
            ctl.ev = EV_RESPONSE;
            ctl.drop_len = 1'b1;
            hdr_ok_in = 1'b0;
            state_in = S_CHK;
         end
         S_RDR: begin
            ctl.data_take = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (st.out_free) begin
               ctl.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // A config write may change the start code: forget the cached header
      if (st.cfg_wr) begin
         hdr_ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         hdr_ok_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         hdr_ok_ff <= hdr_ok_in;
      end
   end

   `STX_ASSERT_IMPL(a_opc_needs_match, clock, reset, state_ff == S_OPC, st.match_en)
   `STX_ASSERT_IMPL(a_lenchk_hdr, clock, reset, state_ff == S_LENCHK, hdr_ok_ff)
   `STX_ASSERT_IMPL(a_capture_after_copy, clock, reset, ctl.capture, $past(state_ff == S_COPY))
endmodule

@@ sv/stx_etx_response_deframer.sv @@
// Top level of the STX/ETX response deframer: controller plus datapath.
// Depends on stxdf_pkg, stxdf_if, stxdf_ctrl and stxdf_dpath.
//
//   channel  dir  handshake      payload
//   req_if   in   valid/ready    cmd, rx_byte, read_index
//   rsp_if   out  valid/ready    response_ready, response_length, read_data, frame_event
//   csr_if   in   valid/ready    index, data (always ready)
//
// A clear, an unused command, a read past the length or a stored byte that leaves a
// known frame open goes straight to the result stage; a read inside the length first
// reads the response memory. A byte that needs a scan checks the start byte, the
// length, the end byte and, with matching on, the opcode, dropping a byte or a whole
// frame as it goes; a matching frame is copied one byte at a time through the single
// read port of the window memory. One item is in work at a time.
// Reset is synchronous; no clearing pass is needed. A stalled result holds
// in the output register; the next item waits for it only at hand-off.
module stx_etx_response_deframer #(
   parameter int WINDOW_DEPTH = 256
) (
   input logic        clock,
   input logic        reset,
   stxdf_req_if.sink  req_if,
   stxdf_rsp_if.source rsp_if,
   stxdf_csr_if.sink  csr_if
);
   import stxdf_pkg::*;

   dp_cmd_type    ctl;
   dp_status_type st;

   assign csr_if.ready = 1'b1;

   stxdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_cmd   (req_if.cmd),
      .req_ready (req_if.ready),
      .st        (st),
      .ctl       (ctl)
   );

   stxdf_dpath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .st                  (st),
      .req_rx_byte         (req_if.rx_byte),
      .req_read_index      (req_if.read_index),
      .csr_valid           (csr_if.valid),
      .csr_index           (csr_if.index),
      .csr_data            (csr_if.data),
      .rsp_ready           (rsp_if.ready),
      .rsp_valid           (rsp_if.valid),
      .rsp_response_ready  (rsp_if.response_ready),
      .rsp_response_length (rsp_if.response_length),
      .rsp_read_data       (rsp_if.read_data),
      .rsp_frame_event     (rsp_if.frame_event)
   );
endmodule

@@ test/tb.sv @@
// Self-checking testbench for the STX/ETX response deframer.
// Depends on stxdf_pkg, the stxdf_if interfaces and stx_etx_response_deframer.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import stxdf_pkg::*;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] rx_byte;
      logic [7:0] read_index;
   } req_word_type;

   typedef struct packed {
      logic       response_ready;
      logic [7:0] response_length;
      logic [7:0] read_data;
      logic [1:0] frame_event;
   } rsp_word_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic clock;
   logic reset;

   stxdf_req_if req_if();
   stxdf_rsp_if rsp_if();
   stxdf_csr_if csr_if();

   stx_etx_response_deframer dut (
      .clock(clock), .reset(reset),
      .req_if(req_if), .rsp_if(rsp_if), .csr_if(csr_if)
   );

   // predictor state
   logic [7:0] pr_start, pr_end, pr_opcode;
   logic       pr_match;
   logic [7:0] win_mem [256];
   int         win_count;
   int         win_head;
   logic [7:0] resp_mem [256];
   logic [7:0] cap_len;
   logic       flag;

   req_word_type pending_words[$];
   rsp_word_type expected_words[$];
   int         errors = 0;
   int         idle_cycles = 0;

   // csr side: written only from the stimulus process
   logic       csr_valid_r;
   logic [7:0] csr_index_r, csr_data_r;

   function automatic logic [7:0] win_at(int k);
      return win_mem[(win_head + k) % 256];
   endfunction

   function automatic void win_drop(int n);
      if (n > win_count) n = win_count;
      win_head  = (win_head + n) % 256;
      win_count = win_count - n;
   endfunction

   // hunt for frames in the window; returns the last event seen
   function automatic logic [1:0] hunt_frames();
      logic [1:0] ev;
      int         len;
      ev = EV_NONE;
      forever begin
         while (win_count > 0 && win_at(0) != pr_start) win_drop(1);
         if (win_count < 2) return ev;
         len = win_at(1);
         if (len < MIN_FRAME) begin
            ev = EV_REJECT;
            win_drop(1);
            continue;
         end
         if (win_count < len) return ev;
         if (win_at(len - 1) != pr_end) begin
            ev = EV_REJECT;
            win_drop(1);
            continue;
         end
         if (pr_match && win_at(6) == (pr_opcode | REPLY_BIT)) begin
            for (int k = 0; k < len; k++) resp_mem[k] = win_at(k);
            cap_len = len[7:0];
            flag    = 1'b1;
            ev      = EV_RESPONSE;
         end else begin
            ev = EV_OTHER;
         end
         win_drop(len);
      end
   endfunction

   function automatic rsp_word_type predict_response(req_word_type w);
      rsp_word_type r;
      r = '0;
      if (w.cmd == CMD_RX) begin
         if (win_count < 256) begin
            win_mem[(win_head + win_count) % 256] = w.rx_byte;
            win_count++;
         end
         r.frame_event = hunt_frames();
      end else if (w.cmd == CMD_READ) begin
         if (w.read_index < cap_len) r.read_data = resp_mem[w.read_index];
      end else if (w.cmd == CMD_CLEAR) begin
         flag = 1'b0;
      end
      r.response_ready  = flag;
      r.response_length = cap_len;
      return r;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // driver: present queued words with random gaps
   int drv_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.cmd <= '0;
         req_if.rx_byte <= '0;
         req_if.read_index <= '0;
         drv_gap = 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid && req_if.ready)
            expected_words.push_back(predict_response('{req_if.cmd, req_if.rx_byte,
                                                         req_if.read_index}));
         if (drv_gap > 0) begin
            drv_gap--;
            req_if.valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_word_type w;
            w = pending_words.pop_front();
            req_if.valid <= 1'b1;
            req_if.cmd <= w.cmd;
            req_if.rx_byte <= w.rx_byte;
            req_if.read_index <= w.read_index;
            drv_gap = gap_len();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // monitor: random stall on the result side, compare each word
   int mon_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         mon_gap = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_word_type got, exp_w;
            got = '{rsp_if.response_ready, rsp_if.response_length,
                    rsp_if.read_data, rsp_if.frame_event};
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word %h", $time, got);
               errors++;
            end else begin
               exp_w = expected_words.pop_front();
               if (got.response_ready !== exp_w.response_ready)
                  $display("%0t: response_ready exp %0d got %0d", $time,
                           exp_w.response_ready, got.response_ready);
               if (got.response_length !== exp_w.response_length)
                  $display("%0t: response_length exp %0d got %0d", $time,
                           exp_w.response_length, got.response_length);
               if (got.read_data !== exp_w.read_data)
                  $display("%0t: read_data exp %0d got %0d", $time,
                           exp_w.read_data, got.read_data);
               if (got.frame_event !== exp_w.frame_event)
                  $display("%0t: frame_event exp %0d got %0d", $time,
                           exp_w.frame_event, got.frame_event);
               if (got !== exp_w) errors++;
            end
         end
         if (mon_gap > 0) begin
            mon_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            mon_gap = gap_len();
         end
      end
   end

   // watchdog on accepted words
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   assign csr_if.valid = csr_valid_r;
   assign csr_if.index = csr_index_r;
   assign csr_if.data  = csr_data_r;

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_if.valid || expected_words.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [7:0] val);
      csr_valid_r <= 1'b1;
      csr_index_r <= idx;
      csr_data_r  <= val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_valid_r <= 1'b0;
      case (idx)
         REG_START:  pr_start  = val;
         REG_END:    pr_end    = val;
         REG_OPCODE: pr_opcode = val;
         REG_MATCH:  pr_match  = val[0];
         default: ;
      endcase
   endtask

   task automatic push_rx(logic [7:0] b);
      pending_words.push_back('{CMD_RX, b, 8'($urandom)});
   endtask

   task automatic push_cmd(logic [1:0] c, logic [7:0] idx);
      pending_words.push_back('{c, 8'($urandom), idx});
   endtask

   // queue one frame; bad_end spoils the closing byte
   task automatic push_frame(int len, bit hit, bit bad_end);
      for (int k = 0; k < len; k++) begin
         logic [7:0] b;
         b = 8'($urandom);
         if (k == 0) b = pr_start;
         else if (k == 1) b = len[7:0];
         else if (k == 6) b = hit ? (pr_opcode | REPLY_BIT) : b;
         else if (k == len - 1) b = bad_end ? ~pr_end : pr_end;
         push_rx(b);
      end
   endtask

   task automatic random_phase(int n);
      int issued;
      issued = 0;
      while (issued < n) begin
         int p, len;
         p = $urandom_range(0, 99);
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 255) : $urandom_range(8, 20);
         if (p < 55) begin
            push_frame(len, $urandom_range(0, 2) != 0, $urandom_range(0, 9) == 0);
            issued += len;
         end else if (p < 70) begin
            push_cmd(CMD_READ, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                            : 8'($urandom_range(0, 20)));
            issued++;
         end else if (p < 75) begin
            push_cmd(CMD_CLEAR, 8'($urandom));
            issued++;
         end else if (p < 77) begin
            push_cmd(CMD_UNUSED, 8'($urandom));
            issued++;
         end else begin
            // noise: raw bytes, sometimes a start code and a small length byte
            push_rx(($urandom_range(0, 3) == 0) ? pr_start : 8'($urandom));
            if ($urandom_range(0, 3) == 0) push_rx(8'($urandom_range(0, 9)));
            issued++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_valid_r = 1'b0;
      csr_index_r = '0;
      csr_data_r = '0;
      pr_start = 8'd2; pr_end = 8'd3; pr_opcode = 8'd0; pr_match = 1'b0;
      win_count = 0; win_head = 0; cap_len = '0; flag = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: frames under reset settings, no capture
      push_frame(8, 1, 0);
      wait_drained();
      write_reg(REG_MATCH, 8'd1);
      push_frame(8, 1, 0);                   // captured
      push_cmd(CMD_READ, 8'd0);
      push_cmd(CMD_READ, 8'd7);
      push_cmd(CMD_READ, 8'd8);              // past the length
      push_cmd(CMD_READ, 8'd255);
      push_rx(pr_start); push_rx(8'd7);      // short frame
      push_frame(9, 1, 1);                   // wrong end byte
      push_frame(8, 0, 0);                   // other frame
      push_cmd(CMD_CLEAR, 8'd0);
      push_cmd(CMD_UNUSED, 8'hff);
      push_rx(8'hff); push_rx(8'h00);
      wait_drained();

      // random phases across settings, extremes included
      write_reg(REG_START, 8'h00); write_reg(REG_END, 8'hff);
      write_reg(REG_OPCODE, 8'h7f);
      random_phase(300);
      wait_drained();                        // sender pauses until all results are in
      write_reg(REG_START, 8'hff); write_reg(REG_END, 8'h00);
      write_reg(REG_OPCODE, 8'hff);
      random_phase(300);
      wait_drained();
      write_reg(REG_START, 8'($urandom)); write_reg(REG_END, 8'($urandom));
      write_reg(REG_OPCODE, 8'($urandom));
      random_phase(250);
      wait_drained();
      write_reg(REG_MATCH, 8'd0);
      write_reg(REG_START, 8'h02); write_reg(REG_END, 8'h03);
      random_phase(150);
      wait_drained();

      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
